@@ sv/bfba_pkg.sv @@
package bfba_pkg;

   localparam int MEMORY_UNITS_DEF = 256;
   localparam int SIZE_W           = 9;
   localparam int START_W          = 8;
   localparam int POS_W            = 8;
   localparam int STATUS_W         = 2;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NOFIT = 2'd1;
   localparam logic [STATUS_W-1:0] ST_ZERO  = 2'd2;

   localparam logic MODE_ALLOC   = 1'b0;
   localparam logic MODE_RELEASE = 1'b1;

   typedef struct packed {
      logic               mode;
      logic [SIZE_W-1:0]  request_size;
      logic [START_W-1:0] release_start;
   } req_type;

   typedef struct packed {
      logic                granted;
      logic [POS_W-1:0]    position;
      logic [STATUS_W-1:0] status;
   } rsp_type;

   // one bitmap bit arriving at the run tracker
   typedef struct packed {
      logic valid;
      logic sentinel;
   } step_type;

endpackage

@@ sv/bfba_bitmap.sv @@
module bfba_bitmap #(
   parameter int MEMORY_UNITS = bfba_pkg::MEMORY_UNITS_DEF
) (
   input  logic                            clock,
   input  logic                            wr_en,
   input  logic [$clog2(MEMORY_UNITS)-1:0] wr_addr,
   input  logic                            wr_data,
   input  logic                            rd_en,
   input  logic [$clog2(MEMORY_UNITS)-1:0] rd_addr,
   output logic                            rd_data
);
   logic mem [MEMORY_UNITS];
   logic rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

@@ sv/bfba_run_tracker.sv @@
module bfba_run_tracker #(
   parameter int MEMORY_UNITS = bfba_pkg::MEMORY_UNITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            clear,
   input  bfba_pkg::step_type              step,
   input  logic [$clog2(MEMORY_UNITS)-1:0] step_idx,
   input  logic                            occupied,
   input  logic [bfba_pkg::SIZE_W-1:0]     size,
   output logic                            have_best,
   output logic [$clog2(MEMORY_UNITS)-1:0] best_start
);
   import bfba_pkg::*;

   localparam int AW = $clog2(MEMORY_UNITS);
   localparam int CW = $clog2(MEMORY_UNITS + 1);
   localparam int LW = (CW > SIZE_W) ? CW : SIZE_W;

   logic [LW-1:0] run_len_ff, run_len_in;
   logic [AW-1:0] run_start_ff, run_start_in;
   logic [LW-1:0] best_left_ff, best_left_in;
   logic [AW-1:0] best_start_ff, best_start_in;
   logic          have_ff, have_in;
   logic          is_free;
   logic          fits;
   logic [LW-1:0] left;

   assign is_free = step.valid && !step.sentinel && !occupied;
   assign fits    = run_len_ff >= LW'(size);
   assign left    = run_len_ff - LW'(size);

   always_comb begin
      run_len_in    = run_len_ff;
      run_start_in  = run_start_ff;
      best_left_in  = best_left_ff;
      best_start_in = best_start_ff;
      have_in       = have_ff;
      if (clear) begin
         run_len_in = '0;
         have_in    = 1'b0;
      end else if (step.valid) begin
         if (is_free) begin
            if (run_len_ff == '0) begin
               run_start_in = step_idx;
            end
            run_len_in = run_len_ff + LW'(1);
         end else if (run_len_ff != '0) begin
            if (fits && (!have_ff || left < best_left_ff)) begin
               have_in       = 1'b1;
               best_left_in  = left;
               best_start_in = run_start_ff;
            end
            run_len_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff    <= 1'b0;
         run_len_ff <= '0;
      end else begin
         have_ff    <= have_in;
         run_len_ff <= run_len_in;
      end
      run_start_ff  <= run_start_in;
      best_left_ff  <= best_left_in;
      best_start_ff <= best_start_in;
   end

   assign have_best  = have_ff;
   assign best_start = best_start_ff;
endmodule

@@ sv/best_fit_bitmap_allocator.sv @@
// Best-fit allocator over a one-bit-per-unit occupancy bitmap (N = MEMORY_UNITS).
// Allocate: a scan reads all N units and a sentinel step ends it; S_SCAN_WAIT and S_DECIDE
// let the run tracker settle, S_MARK writes size units, S_RESP loads the response register.
// Release frees size units (fewer if the run passes the end); zero or oversize: S_RESP.
// One transaction at a time; req_ready returns as the response loads, even while it waits.
// After reset a clearing pass writes every unit free, with req_ready low.
module best_fit_bitmap_allocator #(
   parameter int MEMORY_UNITS = bfba_pkg::MEMORY_UNITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  bfba_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output bfba_pkg::rsp_type rsp_data
);
   import bfba_pkg::*;

   localparam int AW = $clog2(MEMORY_UNITS);
   localparam int CW = $clog2(MEMORY_UNITS + 1);
   localparam int LW = (CW > SIZE_W) ? CW : SIZE_W;
   localparam int UW = LW + 1;
   localparam int PW = (AW > POS_W) ? AW : POS_W;
   localparam logic [CW-1:0] LAST_C  = CW'(MEMORY_UNITS - 1);
   localparam logic [CW-1:0] UNITS_C = CW'(MEMORY_UNITS);

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_SCAN, S_SCAN_WAIT, S_DECIDE, S_MARK, S_RESP
   } state_type;

   state_type         state_ff, state_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [SIZE_W-1:0] mark_ff, mark_in;
   logic [SIZE_W-1:0] size_ff, size_in;
   logic [UW-1:0]     base_ff, base_in;
   logic              wr_val_ff, wr_val_in;
   step_type          step_ff, step_in;
   logic [AW-1:0]     step_idx_ff, step_idx_in;
   rsp_type           res_ff, res_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic              accept;
   logic              trk_clear;
   logic              have_best;
   logic [AW-1:0]     best_start;
   logic [PW-1:0]     pos_wide;
   logic [UW-1:0]     unit;
   logic              mark_done;
   logic              occupied;
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic              wr_data;
   logic              rd_en;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign trk_clear = accept;
   assign pos_wide  = PW'(best_start);
   assign unit      = base_ff + UW'(mark_ff);
   assign mark_done = (mark_ff == size_ff) || (unit >= UW'(MEMORY_UNITS));

   assign wr_en   = (state_ff == S_CLEAR) || ((state_ff == S_MARK) && !mark_done);
   assign wr_addr = (state_ff == S_CLEAR) ? cnt_ff[AW-1:0] : unit[AW-1:0];
   assign wr_data = (state_ff == S_CLEAR) ? 1'b0 : wr_val_ff;
   assign rd_en   = (state_ff == S_SCAN) && (cnt_ff != UNITS_C);

   bfba_bitmap #(.MEMORY_UNITS(MEMORY_UNITS)) u_bitmap (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (cnt_ff[AW-1:0]),
      .rd_data (occupied)
   );

   bfba_run_tracker #(.MEMORY_UNITS(MEMORY_UNITS)) u_tracker (
      .clock      (clock),
      .reset      (reset),
      .clear      (trk_clear),
      .step       (step_ff),
      .step_idx   (step_idx_ff),
      .occupied   (occupied),
      .size       (size_ff),
      .have_best  (have_best),
      .best_start (best_start)
   );

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      mark_in      = mark_ff;
      size_in      = size_ff;
      base_in      = base_ff;
      wr_val_in    = wr_val_ff;
      step_in      = '0;
      step_idx_in  = cnt_ff[AW-1:0];
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         S_CLEAR: begin
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == LAST_C) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               size_in = req_data.request_size;
               cnt_in  = '0;
               mark_in = '0;
               if (req_data.request_size == '0) begin
                  res_in   = '{granted: 1'b0, position: '0, status: ST_ZERO};
                  state_in = S_RESP;
               end else if (req_data.mode == MODE_RELEASE) begin
                  base_in   = UW'(req_data.release_start);
                  wr_val_in = 1'b0;
                  res_in    = '{granted: 1'b1, position: '0, status: ST_OK};
                  state_in  = S_MARK;
               end else if (LW'(req_data.request_size) > LW'(MEMORY_UNITS)) begin
                  res_in   = '{granted: 1'b0, position: '0, status: ST_NOFIT};
                  state_in = S_RESP;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            step_in.valid    = 1'b1;
            step_in.sentinel = (cnt_ff == UNITS_C);
            if (cnt_ff == UNITS_C) begin
               state_in = S_SCAN_WAIT;
            end else begin
               cnt_in = cnt_ff + CW'(1);
            end
         end
         S_SCAN_WAIT: begin
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            if (have_best) begin
               base_in   = UW'(best_start);
               wr_val_in = 1'b1;
               res_in    = '{granted: 1'b1, position: pos_wide[POS_W-1:0], status: ST_OK};
               state_in  = S_MARK;
            end else begin
               res_in   = '{granted: 1'b0, position: '0, status: ST_NOFIT};
               state_in = S_RESP;
            end
         end
         S_MARK: begin
            if (mark_done) begin
               state_in = S_RESP;
            end else begin
               mark_in = mark_ff + SIZE_W'(1);
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         cnt_ff       <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mark_ff     <= mark_in;
      size_ff     <= size_in;
      base_ff     <= base_in;
      wr_val_ff   <= wr_val_in;
      step_idx_ff <= step_idx_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
endmodule

@@ sv/bfba_checker.sv @@
module bfba_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input bfba_pkg::rsp_type rsp_data
);
   import bfba_pkg::*;

   // clearing pass keeps the request side closed right after reset
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("req_ready high right after reset");

   // busy after a transaction is taken
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req_ready high in the cycle after a transaction");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response dropped or changed while stalled");

   a_grant_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.granted == (rsp_data.status == ST_OK)))
      else $error("granted disagrees with status");

   a_denied_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.granted |-> rsp_data.position == '0)
      else $error("nonzero position on a denied transaction");
endmodule

bind best_fit_bitmap_allocator bfba_checker u_bfba_checker (.*);
